FILE: hdl/sha256d_header_nonce_check_unit_defines.svh
// Assertion macros shared by the SHA-256d nonce check unit
`ifndef SHA256D_HEADER_NONCE_CHECK_UNIT_DEFINES_SVH
`define SHA256D_HEADER_NONCE_CHECK_UNIT_DEFINES_SVH

// Clocked check, masked while reset is active
`define SHD_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define SHD_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/shd_pkg.sv
// Types, constants and helper functions for the SHA-256d nonce check unit
`timescale 1ns / 1ps

package shd_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [0:7]  state_t;
    typedef word_t [0:15] block_t;

    typedef struct packed {
        logic  valid;
        word_t nonce;
    } tag_t;

    localparam int unsigned SHA_ROUNDS = 64;
    // Round cells plus feed-forward stage per block, three blocks, one result stage
    localparam int unsigned PIPE_LAT   = 3 * (SHA_ROUNDS + 1) + 1;

    localparam int unsigned CFG_AW = 6;
    localparam int unsigned CFG_DW = 64;

    localparam logic [2:0] REG_VERSION = 3'd0;
    localparam logic [2:0] REG_MERKLE0 = 3'd1;
    localparam logic [2:0] REG_MERKLE1 = 3'd2;
    localparam logic [2:0] REG_MERKLE2 = 3'd3;
    localparam logic [2:0] REG_MERKLE3 = 3'd4;
    localparam logic [2:0] REG_TIME    = 3'd5;
    localparam logic [2:0] REG_BITS    = 3'd6;

    localparam word_t VERSION_RST  = 32'd4;
    localparam word_t PAD_WORD     = 32'h8000_0000;
    localparam word_t LEN_HEADER   = 32'd640;
    localparam word_t LEN_DIGEST   = 32'd256;
    localparam word_t MANT_MASK    = 32'h00ff_ffff;
    localparam logic [7:0] EXP_MIN = 8'd3;
    localparam logic [7:0] EXP_MAX = 8'd32;

    localparam state_t SHA_IV = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t SHA_K [SHA_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(word_t x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t bswap32(word_t x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [255:0] bswap256(logic [255:0] x);
        logic [255:0] r;
        r = '0;
        for (int i = 0; i < 32; i++)
        begin
            r[255 - 8*i -: 8] = x[8*i +: 8];
        end
        return r;
    endfunction

endpackage

FILE: hdl/sha256d_header_nonce_check_unit.sv
// Top level: register file, three block chains and the target compare stage
`timescale 1ns / 1ps
//
//  channel   direction  handshake                     payload
//  config    in/out     psel penable pwrite pready    paddr pwdata prdata
//  nonce     in         start (busy is always low)    nonce
//  result    out        result_valid, one cycle       nonce_echo target_met hash_w0..3
//
//  A nonce enters every clock cycle and passes through three rows of 64 round cells
//  plus a feed-forward add each, and one stage for byte reversal and the target compare.
//  Reset clears the valid bits in every stage and loads the register reset values.
//  Results cannot be stalled; each is shown for exactly one cycle.

`include "sha256d_header_nonce_check_unit_defines.svh"

module sha256d_header_nonce_check_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [shd_pkg::CFG_AW-1:0]  paddr,
    input  logic [shd_pkg::CFG_DW-1:0]  pwdata,
    output logic [shd_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic [31:0]                 nonce,
    output logic                        result_valid,
    output logic [31:0]                 nonce_echo,
    output logic                        target_met,
    output logic [63:0]                 hash_w0,
    output logic [63:0]                 hash_w1,
    output logic [63:0]                 hash_w2,
    output logic [63:0]                 hash_w3
);
    import shd_pkg::*;

    word_t       version_reg;
    logic [63:0] merkle0_reg, merkle1_reg, merkle2_reg, merkle3_reg;
    word_t       time_reg;
    word_t       bits_reg;
    logic [255:0] target_reg, target_next;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    tag_t   tag0, tag1, tag2, tag3;
    state_t dig1, dig2, dig3;
    block_t blk1, blk2, blk3;

    logic [255:0] hash_disp;
    logic         valid_reg;
    word_t        nonce_reg;
    logic         meets_reg;
    logic [255:0] hash_reg;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[CFG_AW-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= VERSION_RST;
            merkle0_reg <= '0;
            merkle1_reg <= '0;
            merkle2_reg <= '0;
            merkle3_reg <= '0;
            time_reg    <= '0;
            bits_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_VERSION: version_reg <= pwdata[31:0];
                REG_MERKLE0: merkle0_reg <= pwdata;
                REG_MERKLE1: merkle1_reg <= pwdata;
                REG_MERKLE2: merkle2_reg <= pwdata;
                REG_MERKLE3: merkle3_reg <= pwdata;
                REG_TIME:    time_reg    <= pwdata[31:0];
                REG_BITS:    bits_reg    <= pwdata[31:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_VERSION: prdata = {32'd0, version_reg};
            REG_MERKLE0: prdata = merkle0_reg;
            REG_MERKLE1: prdata = merkle1_reg;
            REG_MERKLE2: prdata = merkle2_reg;
            REG_MERKLE3: prdata = merkle3_reg;
            REG_TIME:    prdata = {32'd0, time_reg};
            REG_BITS:    prdata = {32'd0, bits_reg};
            default:     prdata = '0;
        endcase
    end

    // Expand the compact target; held in a register since it only moves on config writes
    always_comb
    begin
        target_next = '0;
        if (bits_reg[31:24] >= EXP_MIN && bits_reg[31:24] <= EXP_MAX)
        begin
            target_next = 256'(bits_reg & MANT_MASK)
                          << {8'(bits_reg[31:24] - EXP_MIN), 3'b000};
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
    end

    // First header block: version, zero previous hash, most of the merkle root
    assign tag0 = '{valid: start && !busy, nonce: nonce};
    assign blk1 = '{bswap32(version_reg), 32'd0, 32'd0, 32'd0, 32'd0,
                    32'd0, 32'd0, 32'd0, 32'd0,
                    bswap32(merkle0_reg[31:0]), bswap32(merkle0_reg[63:32]),
                    bswap32(merkle1_reg[31:0]), bswap32(merkle1_reg[63:32]),
                    bswap32(merkle2_reg[31:0]), bswap32(merkle2_reg[63:32]),
                    bswap32(merkle3_reg[31:0])};

    shd_block_chain u_chain1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_i    (tag0),
        .state_i  (SHA_IV),
        .block_i  (blk1),
        .tag_o    (tag1),
        .digest_o (dig1)
    );

    // Second header block: header tail, nonce and padding for 80 bytes
    assign blk2 = '{bswap32(merkle3_reg[63:32]), bswap32(time_reg), bswap32(bits_reg),
                    bswap32(tag1.nonce), PAD_WORD, 32'd0, 32'd0, 32'd0,
                    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, LEN_HEADER};

    shd_block_chain u_chain2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_i    (tag1),
        .state_i  (dig1),
        .block_i  (blk2),
        .tag_o    (tag2),
        .digest_o (dig2)
    );

    // Hash the 32-byte digest again
    assign blk3 = '{dig2[0], dig2[1], dig2[2], dig2[3], dig2[4], dig2[5], dig2[6], dig2[7],
                    PAD_WORD, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, LEN_DIGEST};

    shd_block_chain u_chain3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_i    (tag2),
        .state_i  (SHA_IV),
        .block_i  (blk3),
        .tag_o    (tag3),
        .digest_o (dig3)
    );

    assign hash_disp = bswap256({dig3[0], dig3[1], dig3[2], dig3[3],
                                 dig3[4], dig3[5], dig3[6], dig3[7]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tag3.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nonce_reg <= tag3.nonce;
        hash_reg  <= hash_disp;
        meets_reg <= (hash_disp <= target_reg);
    end

    assign result_valid = valid_reg;
    assign nonce_echo   = nonce_reg;
    assign target_met   = meets_reg;
    assign hash_w0      = hash_reg[255:192];
    assign hash_w1      = hash_reg[191:128];
    assign hash_w2      = hash_reg[127:64];
    assign hash_w3      = hash_reg[63:0];

    `SHD_CHECK(a_latency, (start |-> ##(PIPE_LAT) result_valid), "result strobe missing")
    `SHD_CHECK(a_nonce_tag, (result_valid |-> (nonce_echo == $past(nonce, PIPE_LAT))), "tag lost")
    `SHD_CHECK(a_zero_hash, ((result_valid && hash_reg == '0) |-> target_met), "zero hash missed")
    `SHD_CHECK_ALWAYS(a_no_stall, (!busy), "input side stalled")

endmodule

FILE: hdl/shd_round_cell.sv
// One SHA-256 compression round with its message schedule step
`timescale 1ns / 1ps

module shd_round_cell #(
    parameter int unsigned ROUND = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  shd_pkg::tag_t   tag_i,
    input  shd_pkg::state_t st_i,
    input  shd_pkg::state_t base_i,
    input  shd_pkg::block_t w_i,
    output shd_pkg::tag_t   tag_o,
    output shd_pkg::state_t st_o,
    output shd_pkg::state_t base_o,
    output shd_pkg::block_t w_o
);
    import shd_pkg::*;

    logic   valid_reg;
    word_t  nonce_reg;
    state_t st_reg, st_next;
    state_t base_reg;
    block_t w_reg, w_next;

    word_t big_s0, big_s1, ch, maj, t1, t2, sm0, sm1;

    always_comb
    begin
        big_s1 = rotr(st_i[4], 6) ^ rotr(st_i[4], 11) ^ rotr(st_i[4], 25);
        ch     = (st_i[4] & st_i[5]) ^ (~st_i[4] & st_i[6]);
        t1     = st_i[7] + big_s1 + ch + SHA_K[ROUND] + w_i[0];
        big_s0 = rotr(st_i[0], 2) ^ rotr(st_i[0], 13) ^ rotr(st_i[0], 22);
        maj    = (st_i[0] & st_i[1]) ^ (st_i[0] & st_i[2]) ^ (st_i[1] & st_i[2]);
        t2     = big_s0 + maj;
        st_next = '{t1 + t2, st_i[0], st_i[1], st_i[2],
                    st_i[3] + t1, st_i[4], st_i[5], st_i[6]};

        // Advance the schedule window by one word
        sm0 = rotr(w_i[1], 7) ^ rotr(w_i[1], 18) ^ (w_i[1] >> 3);
        sm1 = rotr(w_i[14], 17) ^ rotr(w_i[14], 19) ^ (w_i[14] >> 10);
        for (int j = 0; j < 15; j++)
        begin
            w_next[j] = w_i[j + 1];
        end
        w_next[15] = w_i[0] + sm0 + w_i[9] + sm1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tag_i.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nonce_reg <= tag_i.nonce;
        st_reg    <= st_next;
        base_reg  <= base_i;
        w_reg     <= w_next;
    end

    assign tag_o  = '{valid: valid_reg, nonce: nonce_reg};
    assign st_o   = st_reg;
    assign base_o = base_reg;
    assign w_o    = w_reg;

endmodule

FILE: hdl/shd_block_chain.sv
// Row of 64 round cells and the feed-forward add for one SHA-256 block
`timescale 1ns / 1ps

module shd_block_chain (
    input  logic            clk,
    input  logic            rst_n,
    input  shd_pkg::tag_t   tag_i,
    input  shd_pkg::state_t state_i,
    input  shd_pkg::block_t block_i,
    output shd_pkg::tag_t   tag_o,
    output shd_pkg::state_t digest_o
);
    import shd_pkg::*;

    tag_t   tag_s  [SHA_ROUNDS + 1];
    state_t st_s   [SHA_ROUNDS + 1];
    state_t base_s [SHA_ROUNDS + 1];
    block_t w_s    [SHA_ROUNDS + 1];

    logic   valid_reg;
    word_t  nonce_reg;
    state_t digest_reg, digest_next;

    assign tag_s[0]  = tag_i;
    assign st_s[0]   = state_i;
    assign base_s[0] = state_i;
    assign w_s[0]    = block_i;

    for (genvar r = 0; r < SHA_ROUNDS; r++)
    begin : g_round
        shd_round_cell #(
            .ROUND (r)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .tag_i  (tag_s[r]),
            .st_i   (st_s[r]),
            .base_i (base_s[r]),
            .w_i    (w_s[r]),
            .tag_o  (tag_s[r + 1]),
            .st_o   (st_s[r + 1]),
            .base_o (base_s[r + 1]),
            .w_o    (w_s[r + 1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            digest_next[i] = st_s[SHA_ROUNDS][i] + base_s[SHA_ROUNDS][i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tag_s[SHA_ROUNDS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nonce_reg  <= tag_s[SHA_ROUNDS].nonce;
        digest_reg <= digest_next;
    end

    assign tag_o    = '{valid: valid_reg, nonce: nonce_reg};
    assign digest_o = digest_reg;

endmodule
